FILE: hdl/udp_feed_message_extractor_assert.svh
`ifndef UDP_FEED_MESSAGE_EXTRACTOR_ASSERT_SVH
`define UDP_FEED_MESSAGE_EXTRACTOR_ASSERT_SVH

// same-cycle implication
`define UFME_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ufme assertion failed");

// next-cycle implication
`define UFME_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ufme assertion failed");

`endif

FILE: hdl/ufme_pkg.sv
package ufme_pkg;

    typedef struct packed {
        logic [7:0]  frame_byte;
        logic        frame_first;
        logic [15:0] capture_length;
        logic [31:0] capture_seconds;
        logic [19:0] capture_micros;
    } t_frame_item;

    typedef struct packed {
        logic [7:0]  message_byte;
        logic        message_first;
        logic        message_last;
        logic [15:0] message_length;
        logic [61:0] timestamp_ns;
        logic [63:0] message_seq;
    } t_msg_item;

    typedef struct packed {
        logic [7:0]  reg_index;
        logic [15:0] reg_value;
    } t_cfg_write;

    localparam logic [7:0]  CFG_MIN_MESSAGE_LENGTH      = 8'd0;
    localparam logic [7:0]  CFG_TRANSPORT_HEADER_LENGTH = 8'd1;

    localparam logic [15:0] MIN_MESSAGE_LENGTH_RESET      = 16'd9;
    localparam logic [7:0]  TRANSPORT_HEADER_LENGTH_RESET = 8'd8;

    localparam logic [15:0] MIN_CAPTURE_BYTES = 16'd34;
    localparam logic [15:0] ETH_HDR_BYTES     = 16'd14;
    localparam logic [15:0] UDP_HDR_BYTES     = 16'd8;
    localparam logic [15:0] POS_ETYPE_HI      = 16'd12;
    localparam logic [15:0] POS_ETYPE_LO      = 16'd13;
    localparam logic [15:0] POS_IHL           = 16'd14;
    localparam logic [15:0] POS_PROTOCOL      = 16'd23;
    localparam logic [7:0]  ETYPE_IPV4_HI     = 8'h08;
    localparam logic [7:0]  ETYPE_IPV4_LO     = 8'h00;
    localparam logic [7:0]  IP_PROTO_UDP      = 8'd17;
    localparam logic [3:0]  IHL_MASK          = 4'hF;
    localparam logic [3:0]  IHL_MIN           = 4'd5;
    localparam logic [15:0] MSG_LENGTH_FLOOR  = 16'd2;

    localparam logic [61:0] NS_PER_SECOND = 62'd1000000000;
    localparam logic [29:0] NS_PER_MICRO  = 30'd1000;

endpackage

FILE: hdl/ufme_stream_if.sv
interface ufme_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/udp_feed_message_extractor.sv
// Channel   Dir   Payload              Transfer
// i_frame   in    ufme_pkg::t_frame_item valid & ready
// i_cfg     in    ufme_pkg::t_cfg_write  valid & ready (ready always high)
// o_msg     out   ufme_pkg::t_msg_item   valid & ready
//
// One frame byte per cycle; the parse step sits between an input register and a
// 4-entry result queue, and advances when two queue slots are free.
// A byte yields up to two message bytes; o_msg drains one per cycle while ready.
// Capture time is scaled to ns through r_sec/r_us, r_ts_sec/r_ts_us, then r_ts.
// Reset is synchronous, active low; it clears control state and the queue.
// A stalled o_msg fills the queue past two entries and then holds off i_frame.
module udp_feed_message_extractor #(
    parameter int LENGTH_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    ufme_stream_if.sink           i_frame,
    ufme_stream_if.sink           i_cfg,
    ufme_stream_if.source         o_msg
);

    `include "udp_feed_message_extractor_assert.svh"

    localparam int LB     = LENGTH_BITS;
    localparam int DEPTH  = 4;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam logic [LB-1:0] LEN_MAX = '1;

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_HEADER = 3'd1;
    localparam logic [2:0] PH_LEN_HI = 3'd2;
    localparam logic [2:0] PH_LEN_LO = 3'd3;
    localparam logic [2:0] PH_BODY   = 3'd4;
    localparam logic [2:0] PH_DROP   = 3'd5;

    logic                  r_in_v;
    ufme_pkg::t_frame_item r_in;
    logic                  w_go;

    logic [2:0]    r_phase, n_phase;
    logic [LB-1:0] r_pos, n_pos;
    logic [LB-1:0] r_flen, n_flen;
    logic [8:0]    r_start, n_start;
    logic [7:0]    r_held, n_held;
    logic [LB-1:0] r_left, n_left;
    logic          r_seen, n_seen;
    logic [LB-1:0] r_cur, n_cur;
    logic [63:0]   r_seq, n_seq;
    logic [31:0]   r_sec, n_sec;
    logic [19:0]   r_us, n_us;
    logic [61:0]   r_ts_sec;
    logic [29:0]   r_ts_us;
    logic [61:0]   r_ts;

    logic [15:0]   r_min;
    logic [7:0]    r_thl;

    ufme_pkg::t_msg_item r_mem [DEPTH];
    logic [PTR_W-1:0]    r_wp, r_rp;
    logic [CNT_W-1:0]    r_cnt;
    ufme_pkg::t_msg_item w_item0, w_item1;
    logic [1:0]          w_npush;
    logic                w_pop;
    logic                w_out_first;
    logic                w_short_start;

    assign w_go          = r_in_v && (r_cnt <= CNT_W'(DEPTH - 2));
    assign i_frame.ready = !r_in_v || w_go;
    assign i_cfg.ready   = 1'b1;
    assign w_pop         = o_msg.valid && o_msg.ready;
    assign o_msg.valid   = (r_cnt != '0);
    assign o_msg.data    = r_mem[r_rp];

    assign w_out_first   = o_msg.valid && o_msg.data.message_first;
    assign w_short_start = w_go && r_in.frame_first
                        && (r_in.capture_length < ufme_pkg::MIN_CAPTURE_BYTES);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (i_frame.ready) begin
            r_in_v <= i_frame.valid;
        end
        if (i_frame.ready && i_frame.valid) begin
            r_in <= i_frame.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= ufme_pkg::MIN_MESSAGE_LENGTH_RESET;
            r_thl <= ufme_pkg::TRANSPORT_HEADER_LENGTH_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.data.reg_index)
                ufme_pkg::CFG_MIN_MESSAGE_LENGTH: begin
                    r_min <= i_cfg.data.reg_value;
                end
                ufme_pkg::CFG_TRANSPORT_HEADER_LENGTH: begin
                    r_thl <= i_cfg.data.reg_value[7:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        logic        v_adv;
        logic [16:0] v_pos17;
        logic [16:0] v_flen17;
        logic [8:0]  v_start;
        logic [3:0]  v_ihl;
        logic [7:0]  v_b;
        logic [15:0] v_len;
        logic [15:0] v_mn;

        n_phase = r_phase;
        n_pos   = r_pos;
        n_flen  = r_flen;
        n_start = r_start;
        n_held  = r_held;
        n_left  = r_left;
        n_seen  = r_seen;
        n_cur   = r_cur;
        n_seq   = r_seq;
        n_sec   = r_sec;
        n_us    = r_us;
        w_npush = 2'd0;
        v_adv   = 1'b0;
        v_pos17  = '0;
        v_flen17 = '0;
        v_start = '0;
        v_ihl   = '0;
        v_len   = '0;
        v_mn    = '0;
        v_b     = r_in.frame_byte;

        w_item0.message_byte    = v_b;
        w_item0.message_first   = 1'b0;
        w_item0.message_last    = 1'b0;
        w_item0.message_length  = 16'(r_cur);
        w_item0.timestamp_ns    = r_ts;
        w_item0.message_seq     = r_seq - 64'd1;
        w_item1                 = w_item0;

        if (w_go) begin
            if (r_in.frame_first) begin
                if (17'(r_in.capture_length) > 17'(LEN_MAX)) begin
                    n_flen = LEN_MAX;
                end else begin
                    n_flen = LB'(r_in.capture_length);
                end
                n_pos   = '0;
                n_start = '0;
                n_held  = '0;
                n_left  = '0;
                n_seen  = 1'b0;
                n_cur   = '0;
                n_sec   = r_in.capture_seconds;
                n_us    = r_in.capture_micros;
                n_phase = (17'(n_flen) < 17'(ufme_pkg::MIN_CAPTURE_BYTES)) ? PH_DROP
                                                                          : PH_HEADER;
            end

            v_pos17  = 17'(n_pos);
            v_flen17 = 17'(n_flen);

            if (n_phase != PH_IDLE && n_phase != PH_DROP) begin
                if (v_pos17 >= v_flen17) begin
                    n_phase = PH_DROP;
                end else begin
                    v_adv = 1'b1;
                    case (n_phase)
                        PH_HEADER: begin
                            if (v_pos17 == 17'(ufme_pkg::POS_ETYPE_HI)) begin
                                n_held = v_b;
                            end else if (v_pos17 == 17'(ufme_pkg::POS_ETYPE_LO)) begin
                                if (n_held != ufme_pkg::ETYPE_IPV4_HI
                                    || v_b != ufme_pkg::ETYPE_IPV4_LO) begin
                                    n_phase = PH_DROP;
                                    v_adv   = 1'b0;
                                end
                            end else if (v_pos17 == 17'(ufme_pkg::POS_IHL)) begin
                                v_ihl = v_b[3:0] & ufme_pkg::IHL_MASK;
                                v_start = 9'(ufme_pkg::ETH_HDR_BYTES) + 9'({v_ihl, 2'b00})
                                        + 9'(ufme_pkg::UDP_HDR_BYTES) + 9'(r_thl);
                                if (v_ihl < ufme_pkg::IHL_MIN
                                    || v_flen17 <= 17'(v_start)) begin
                                    n_phase = PH_DROP;
                                    v_adv   = 1'b0;
                                end else begin
                                    n_start = v_start;
                                end
                            end else if (v_pos17 == 17'(ufme_pkg::POS_PROTOCOL)) begin
                                if (v_b != ufme_pkg::IP_PROTO_UDP) begin
                                    n_phase = PH_DROP;
                                    v_adv   = 1'b0;
                                end
                            end
                            if (v_adv && v_pos17 >= 17'(ufme_pkg::POS_IHL)
                                && (v_pos17 + 17'd1) == 17'(n_start)) begin
                                n_phase = PH_LEN_HI;
                            end
                        end
                        PH_LEN_HI: begin
                            n_held  = v_b;
                            n_phase = PH_LEN_LO;
                        end
                        PH_LEN_LO: begin
                            v_len = {n_held, v_b};
                            v_mn  = (r_min < ufme_pkg::MSG_LENGTH_FLOOR)
                                  ? ufme_pkg::MSG_LENGTH_FLOOR : r_min;
                            if (v_len >= v_mn
                                && (v_pos17 - 17'd1) + 17'(v_len) <= v_flen17) begin
                                n_seen  = 1'b1;
                                n_cur   = LB'(v_len);
                                n_seq   = r_seq + 64'd1;
                                w_item0.message_byte    = n_held;
                                w_item0.message_first   = 1'b1;
                                w_item0.message_length  = v_len;
                                w_item0.message_seq     = r_seq;
                                w_item1.message_byte    = v_b;
                                w_item1.message_length  = v_len;
                                w_item1.message_seq     = r_seq;
                                w_item1.message_last    = (v_len == ufme_pkg::MSG_LENGTH_FLOOR);
                                w_npush = 2'd2;
                                n_left  = LB'(v_len - ufme_pkg::MSG_LENGTH_FLOOR);
                                n_phase = (n_left == '0) ? PH_LEN_HI : PH_BODY;
                            end else if (n_seen) begin
                                n_phase = PH_DROP;
                                v_adv   = 1'b0;
                            end else begin
                                n_held = v_b;
                            end
                        end
                        PH_BODY: begin
                            n_left = n_left - LB'(1);
                            w_item0.message_last = (n_left == '0);
                            w_npush = 2'd1;
                            if (n_left == '0) begin
                                n_phase = PH_LEN_HI;
                            end
                        end
                        default: begin
                            n_phase = PH_DROP;
                            v_adv   = 1'b0;
                        end
                    endcase
                    if (v_adv) begin
                        n_pos = n_pos + LB'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_pos   <= '0;
            r_flen  <= '0;
            r_start <= '0;
            r_held  <= '0;
            r_left  <= '0;
            r_seen  <= 1'b0;
            r_cur   <= '0;
            r_seq   <= '0;
        end else begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_flen  <= n_flen;
            r_start <= n_start;
            r_held  <= n_held;
            r_left  <= n_left;
            r_seen  <= n_seen;
            r_cur   <= n_cur;
            r_seq   <= n_seq;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sec    <= n_sec;
        r_us     <= n_us;
        r_ts_sec <= 62'(r_sec) * ufme_pkg::NS_PER_SECOND;
        r_ts_us  <= 30'(r_us) * ufme_pkg::NS_PER_MICRO;
        r_ts     <= r_ts_sec + 62'(r_ts_us);
    end

    always_ff @(posedge i_clk) begin
        if (w_npush != 2'd0) begin
            r_mem[r_wp] <= w_item0;
        end
        if (w_npush == 2'd2) begin
            r_mem[r_wp + PTR_W'(1)] <= w_item1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + PTR_W'(w_npush);
            r_rp  <= r_rp + PTR_W'(w_pop);
            r_cnt <= r_cnt + CNT_W'(w_npush) - CNT_W'(w_pop);
        end
    end

    `UFME_ASSERT_IMPL(a_queue_bound, i_clk, i_rst_n, 1'b1, r_cnt <= CNT_W'(DEPTH))
    `UFME_ASSERT_IMPL(a_left_in_body, i_clk, i_rst_n, r_left != '0, r_phase == PH_BODY)
    `UFME_ASSERT_IMPL(a_first_not_last, i_clk, i_rst_n, w_out_first, !o_msg.data.message_last)
    `UFME_ASSERT_NEXT(a_short_drop, i_clk, i_rst_n, w_short_start, r_phase == PH_DROP)

endmodule

FILE: tb/ufme_message_checker.sv
module ufme_message_checker #(
    parameter int LENGTH_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_frame_valid,
    input  logic                  i_frame_ready,
    input  ufme_pkg::t_frame_item i_frame_data,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  ufme_pkg::t_cfg_write  i_cfg_data,
    input  logic                  i_msg_valid,
    input  logic                  i_msg_ready,
    input  ufme_pkg::t_msg_item   i_msg_data,
    output int                    o_errors,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPTURE_MAX = (1 << LENGTH_BITS) - 1;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEADER,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_BODY,
        PH_DROP
    } t_parse_phase;

    logic [15:0]  min_msg_len;
    logic [7:0]   xport_hdr_len;

    t_parse_phase phase;
    logic [15:0]  byte_pos;
    logic [15:0]  frame_len;
    logic [5:0]   ip_hdr_bytes;
    logic [15:0]  payload_len;
    logic [7:0]   held;
    logic [15:0]  msg_left;
    logic         first_seen;
    logic [61:0]  frame_ts;
    logic [63:0]  msg_count;
    logic [15:0]  msg_len;

    ufme_pkg::t_msg_item msg_expect_q[$];

    task automatic clear_parser();
        min_msg_len   = ufme_pkg::MIN_MESSAGE_LENGTH_RESET;
        xport_hdr_len = ufme_pkg::TRANSPORT_HEADER_LENGTH_RESET;
        phase         = PH_IDLE;
        byte_pos      = '0;
        frame_len     = '0;
        ip_hdr_bytes  = '0;
        payload_len   = '0;
        held          = '0;
        msg_left      = '0;
        first_seen    = 1'b0;
        frame_ts      = '0;
        msg_count     = '0;
        msg_len       = '0;
        msg_expect_q.delete();
    endtask

    function automatic void expect_msg_byte(input logic [7:0] b, input logic first,
                                            input logic last);
        ufme_pkg::t_msg_item m;
        m.message_byte    = b;
        m.message_first   = first;
        m.message_last    = last;
        m.message_length  = msg_len;
        m.timestamp_ns    = frame_ts;
        m.message_seq     = msg_count - 64'd1;
        msg_expect_q.push_back(m);
    endfunction

    task automatic parse_frame_byte(input ufme_pkg::t_frame_item it);
        logic [7:0]  b;
        logic [3:0]  ihl;
        logic [15:0] len;
        logic [63:0] ts;
        int          hdr_end;
        int          floor_len;
        b = it.frame_byte;
        if (it.frame_first) begin
            frame_len = (int'(it.capture_length) > CAPTURE_MAX) ? 16'(CAPTURE_MAX)
                                                                : it.capture_length;
            ts = 64'(it.capture_seconds) * 64'(ufme_pkg::NS_PER_SECOND)
               + 64'(it.capture_micros) * 64'(ufme_pkg::NS_PER_MICRO);
            frame_ts     = ts[61:0];
            byte_pos     = '0;
            ip_hdr_bytes = '0;
            payload_len  = '0;
            held         = '0;
            msg_left     = '0;
            first_seen   = 1'b0;
            msg_len      = '0;
            phase        = (frame_len < ufme_pkg::MIN_CAPTURE_BYTES) ? PH_DROP : PH_HEADER;
        end
        if (phase == PH_IDLE || phase == PH_DROP) return;
        if (byte_pos >= frame_len) begin
            phase = PH_DROP;
            return;
        end
        case (phase)
            PH_HEADER: begin
                if (byte_pos == ufme_pkg::POS_ETYPE_HI) begin
                    held = b;
                end else if (byte_pos == ufme_pkg::POS_ETYPE_LO) begin
                    if (held != ufme_pkg::ETYPE_IPV4_HI || b != ufme_pkg::ETYPE_IPV4_LO) begin
                        phase = PH_DROP;
                        return;
                    end
                end else if (byte_pos == ufme_pkg::POS_IHL) begin
                    ihl = b[3:0] & ufme_pkg::IHL_MASK;
                    if (ihl < ufme_pkg::IHL_MIN) begin
                        phase = PH_DROP;
                        return;
                    end
                    ip_hdr_bytes = {ihl, 2'b00};
                    hdr_end = int'(ufme_pkg::ETH_HDR_BYTES) + int'(ip_hdr_bytes)
                            + int'(ufme_pkg::UDP_HDR_BYTES) + int'(xport_hdr_len);
                    if (int'(frame_len) <= hdr_end) begin
                        phase = PH_DROP;
                        return;
                    end
                    payload_len = frame_len - 16'(hdr_end);
                end else if (byte_pos == ufme_pkg::POS_PROTOCOL) begin
                    if (b != ufme_pkg::IP_PROTO_UDP) begin
                        phase = PH_DROP;
                        return;
                    end
                end
                if (byte_pos >= ufme_pkg::POS_IHL
                    && int'(byte_pos) + 1 == int'(frame_len) - int'(payload_len))
                    phase = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                held  = b;
                phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                len = {held, b};
                floor_len = (min_msg_len < ufme_pkg::MSG_LENGTH_FLOOR)
                          ? int'(ufme_pkg::MSG_LENGTH_FLOOR) : int'(min_msg_len);
                if (int'(len) >= floor_len
                    && int'(byte_pos) - 1 + int'(len) <= int'(frame_len)) begin
                    first_seen = 1'b1;
                    msg_len    = len;
                    msg_count  = msg_count + 64'd1;
                    expect_msg_byte(held, 1'b1, 1'b0);
                    expect_msg_byte(b, 1'b0, len == ufme_pkg::MSG_LENGTH_FLOOR);
                    msg_left = len - ufme_pkg::MSG_LENGTH_FLOOR;
                    phase    = (msg_left == 16'd0) ? PH_LEN_HI : PH_BODY;
                end else if (first_seen) begin
                    phase = PH_DROP;
                    return;
                end else begin
                    held = b;
                end
            end
            PH_BODY: begin
                msg_left = msg_left - 16'd1;
                expect_msg_byte(b, 1'b0, msg_left == 16'd0);
                if (msg_left == 16'd0) phase = PH_LEN_HI;
            end
            default: begin
                phase = PH_DROP;
                return;
            end
        endcase
        byte_pos = byte_pos + 16'd1;
    endtask

    function automatic void compare_field(input string name, input logic [63:0] want,
                                          input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            o_errors++;
        end
    endfunction

    task automatic check_message(input ufme_pkg::t_msg_item got);
        ufme_pkg::t_msg_item want;
        if (msg_expect_q.size() == 0) begin
            $error("unexpected message transfer: message_byte %0h, message_seq %0d",
                   got.message_byte, got.message_seq);
            o_errors++;
            return;
        end
        want = msg_expect_q.pop_front();
        compare_field("message_byte", 64'(want.message_byte), 64'(got.message_byte));
        compare_field("message_first", 64'(want.message_first), 64'(got.message_first));
        compare_field("message_last", 64'(want.message_last), 64'(got.message_last));
        compare_field("message_length", 64'(want.message_length), 64'(got.message_length));
        compare_field("timestamp_ns", 64'(want.timestamp_ns), 64'(got.timestamp_ns));
        compare_field("message_seq", want.message_seq, got.message_seq);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_parser();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_data.reg_index)
                    ufme_pkg::CFG_MIN_MESSAGE_LENGTH:
                        min_msg_len = i_cfg_data.reg_value;
                    ufme_pkg::CFG_TRANSPORT_HEADER_LENGTH:
                        xport_hdr_len = i_cfg_data.reg_value[7:0];
                    default: ;
                endcase
            end
            if (i_frame_valid && i_frame_ready) parse_frame_byte(i_frame_data);
            if (i_msg_valid && i_msg_ready) check_message(i_msg_data);
        end
        o_pending = msg_expect_q.size();
    end

endmodule

FILE: tb/udp_feed_message_extractor_tb.sv
module udp_feed_message_extractor_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_QUOTA = 1950;
    localparam int NUM_SETTINGS = 6;

    logic clk = 1'b0;
    logic rst_n;

    ufme_stream_if #(.T(ufme_pkg::t_frame_item)) frame_if ();
    ufme_stream_if #(.T(ufme_pkg::t_cfg_write))  cfg_if ();
    ufme_stream_if #(.T(ufme_pkg::t_msg_item))   msg_if ();

    int       fail_count;
    int       pending;
    bit       idle_on = 1'b1;
    int       bytes_sent;
    int       cur_min_len = int'(ufme_pkg::MIN_MESSAGE_LENGTH_RESET);
    int       cur_xport_len = int'(ufme_pkg::TRANSPORT_HEADER_LENGTH_RESET);
    bit [7:0] frame_bytes[$];

    int min_len_set[NUM_SETTINGS]   = '{2, 9, 0, 20, 65535, 3};
    int xport_len_set[NUM_SETTINGS] = '{0, 8, 255, 5, 1, 16};

    udp_feed_message_extractor #(.LENGTH_BITS(16)) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_frame (frame_if),
        .i_cfg   (cfg_if),
        .o_msg   (msg_if)
    );

    ufme_message_checker #(.LENGTH_BITS(16)) chk (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_frame_valid (frame_if.valid),
        .i_frame_ready (frame_if.ready),
        .i_frame_data  (frame_if.data),
        .i_cfg_valid   (cfg_if.valid),
        .i_cfg_ready   (cfg_if.ready),
        .i_cfg_data    (cfg_if.data),
        .i_msg_valid   (msg_if.valid),
        .i_msg_ready   (msg_if.ready),
        .i_msg_data    (msg_if.data),
        .o_errors      (fail_count),
        .o_pending     (pending)
    );

    always #5 clk = ~clk;

    task automatic send_byte(input ufme_pkg::t_frame_item it);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            frame_if.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        frame_if.valid <= 1'b1;
        frame_if.data  <= it;
        while (!frame_if.ready) @(negedge clk);
        @(negedge clk);
        bytes_sent++;
    endtask

    task automatic send_frame(input int cap, input logic [31:0] sec, input logic [19:0] us);
        ufme_pkg::t_frame_item it;
        foreach (frame_bytes[i]) begin
            it.frame_byte  = frame_bytes[i];
            it.frame_first = (i == 0);
            if (i == 0) begin
                it.capture_length  = 16'(cap);
                it.capture_seconds = sec;
                it.capture_micros  = us;
            end else begin
                it.capture_length  = 16'($urandom);
                it.capture_seconds = $urandom;
                it.capture_micros  = 20'($urandom);
            end
            send_byte(it);
        end
    endtask

    task automatic send_stray(input int count);
        ufme_pkg::t_frame_item it;
        repeat (count) begin
            it = {8'($urandom), 1'b0, 16'($urandom), 32'($urandom), 20'($urandom)};
            send_byte(it);
        end
    endtask

    function automatic logic [19:0] random_micros();
        if ($urandom_range(0, 7) == 0) return 20'($urandom);
        return 20'($urandom_range(0, 999999));
    endfunction

    task automatic send_random_timed(input int cap);
        send_frame(cap, $urandom, random_micros());
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
        ufme_pkg::t_cfg_write w;
        w.reg_index = idx;
        w.reg_value = val;
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= w;
        while (!cfg_if.ready) @(negedge clk);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        frame_if.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (16) @(negedge clk);
    endtask

    task automatic set_config(input int min_len, input int xport_len);
        wait_drained();
        write_reg(ufme_pkg::CFG_MIN_MESSAGE_LENGTH, 16'(min_len));
        write_reg(ufme_pkg::CFG_TRANSPORT_HEADER_LENGTH, 16'(xport_len));
        cfg_if.valid <= 1'b0;
        cur_min_len   = min_len;
        cur_xport_len = xport_len;
    endtask

    function automatic int pick_msg_len(input int min_len);
        int floor_len;
        floor_len = (min_len < int'(ufme_pkg::MSG_LENGTH_FLOOR))
                  ? int'(ufme_pkg::MSG_LENGTH_FLOOR) : min_len;
        if (floor_len > 48) return $urandom_range(2, 48);
        if ($urandom_range(0, 3) == 0) return floor_len;
        return $urandom_range(floor_len, floor_len + 12);
    endfunction

    function automatic void push_random(input int count);
        repeat (count) frame_bytes.push_back(8'($urandom));
    endfunction

    function automatic void build_udp_frame(input int xport_len, input int ihl,
                                            input int n_msgs, input int junk);
        int len;
        frame_bytes.delete();
        push_random(12);
        frame_bytes.push_back(ufme_pkg::ETYPE_IPV4_HI);
        frame_bytes.push_back(ufme_pkg::ETYPE_IPV4_LO);
        frame_bytes.push_back({4'($urandom), 4'(ihl)});
        push_random(8);
        frame_bytes.push_back(ufme_pkg::IP_PROTO_UDP);
        push_random(ihl * 4 - 10 + int'(ufme_pkg::UDP_HDR_BYTES) + xport_len);
        repeat (junk) frame_bytes.push_back($urandom_range(0, 1) ? 8'hFF : 8'($urandom));
        repeat (n_msgs) begin
            len = pick_msg_len(cur_min_len);
            frame_bytes.push_back(8'(len >> 8));
            frame_bytes.push_back(8'(len));
            push_random(len - 2);
        end
    endfunction

    function automatic void trim_to(input int keep);
        while (frame_bytes.size() > keep) void'(frame_bytes.pop_back());
    endfunction

    task automatic send_random_frame();
        int kind;
        int cap;
        int ihl;
        ihl = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 15) : int'(ufme_pkg::IHL_MIN);
        build_udp_frame(cur_xport_len, ihl, $urandom_range(1, 5),
                        ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0);
        if ($urandom_range(0, 4) == 0) begin
            frame_bytes.push_back(8'h00);
            frame_bytes.push_back(8'h01);
            push_random($urandom_range(0, 3));
        end
        cap  = frame_bytes.size();
        kind = $urandom_range(0, 99);
        if (kind < 60) begin
        end else if (kind < 68) begin
            cap = cap - $urandom_range(1, 10);
        end else if (kind < 76) begin
            trim_to($urandom_range(1, frame_bytes.size() - 1));
        end else if (kind < 80) begin
            frame_bytes[12] = 8'($urandom);
        end else if (kind < 84) begin
            frame_bytes[13] = 8'($urandom_range(1, 255));
        end else if (kind < 88) begin
            frame_bytes[14] = {frame_bytes[14][7:4], 4'($urandom_range(0, 4))};
        end else if (kind < 92) begin
            frame_bytes[23] = 8'($urandom);
        end else if (kind < 96) begin
            cap = $urandom_range(0, 33);
            trim_to($urandom_range(1, 40));
        end else begin
            frame_bytes.delete();
            push_random($urandom_range(1, 40));
            cap = $urandom_range(0, 65535);
        end
        send_random_timed(cap);
    endtask

    initial begin
        msg_if.ready = 1'b0;
        @(negedge clk);
        forever begin
            if (idle_on && $urandom_range(0, 3) == 0) begin
                msg_if.ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge clk);
            end
            msg_if.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
    end

    initial begin
        int phase_start;
        int phase_quota;
        frame_if.valid = 1'b0;
        frame_if.data  = '0;
        cfg_if.valid   = 1'b0;
        cfg_if.data    = '0;
        rst_n          = 1'b0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        build_udp_frame(cur_xport_len, int'(ufme_pkg::IHL_MIN), 2, 0);
        send_frame(frame_bytes.size(), 32'hFFFF_FFFF, 20'hF_FFFF);
        build_udp_frame(cur_xport_len, 15, 3, 3);
        send_frame(frame_bytes.size(), 32'h0, 20'h0);
        build_udp_frame(cur_xport_len, int'(ufme_pkg::IHL_MIN), 1, 0);
        send_random_timed(33);
        build_udp_frame(cur_xport_len, int'(ufme_pkg::IHL_MIN), 1, 0);
        frame_bytes[12] = 8'h86;
        send_random_timed(frame_bytes.size());
        send_stray(3);
        build_udp_frame(cur_xport_len, int'(ufme_pkg::IHL_MIN), 1, 0);
        frame_bytes[14] = 8'h44;
        send_random_timed(frame_bytes.size());
        build_udp_frame(cur_xport_len, int'(ufme_pkg::IHL_MIN), 1, 0);
        frame_bytes[23] = 8'd6;
        send_random_timed(frame_bytes.size());
        build_udp_frame(cur_xport_len, int'(ufme_pkg::IHL_MIN), 3, 0);
        send_random_timed(frame_bytes.size() + 20);
        build_udp_frame(cur_xport_len, int'(ufme_pkg::IHL_MIN), 3, 0);
        send_random_timed(frame_bytes.size() - 5);

        set_config(2, 0);
        build_udp_frame(cur_xport_len, int'(ufme_pkg::IHL_MIN), 1, 0);
        frame_bytes.push_back(8'h00);
        frame_bytes.push_back(8'h02);
        frame_bytes.push_back(8'h00);
        frame_bytes.push_back(8'h02);
        send_random_timed(frame_bytes.size());

        set_config(0, 0);
        build_udp_frame(cur_xport_len, int'(ufme_pkg::IHL_MIN), 1, 0);
        frame_bytes.push_back(8'h00);
        frame_bytes.push_back(8'h02);
        frame_bytes.push_back(8'h00);
        frame_bytes.push_back(8'h01);
        frame_bytes.push_back(8'h00);
        frame_bytes.push_back(8'h00);
        send_random_timed(frame_bytes.size());

        phase_quota = (ITEM_QUOTA > bytes_sent) ? (ITEM_QUOTA - bytes_sent) / NUM_SETTINGS
                                                : 1;
        for (int s = 0; s < NUM_SETTINGS; s++) begin
            set_config(min_len_set[s], xport_len_set[s]);
            if (s == NUM_SETTINGS - 1) idle_on = 1'b0;
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < phase_quota) begin
                if ($urandom_range(0, 4) == 0) send_stray($urandom_range(1, 3));
                send_random_frame();
            end
        end

        wait_drained();
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule
